// ===== hdl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce press classifier package
// Shared widths, operation codes, register indexes, reset values and the
// structs that travel between the core and its per-button slices.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Number of buttons handled by the block.
  localparam int NumButtons = 3;

  // Payload field widths.
  localparam int OpW    = 2;
  localparam int RawW   = 3;
  localparam int IdxW   = 4;
  localparam int LevelW = 3;

  // Hold and repeat counters, and the configuration registers.
  localparam int CntW     = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // Operation codes carried in the op field.
  localparam logic [OpW-1:0] OP_TICK     = 2'd0;
  localparam logic [OpW-1:0] OP_RD_SHORT = 2'd1;
  localparam logic [OpW-1:0] OP_RD_LONG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT     = 1'b1;

  // Register reset values.
  localparam logic [CntW-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [CntW-1:0] REPEAT_RST     = 16'd25;

  // Per-button commands from the core.
  typedef struct packed {
    logic tick;
    logic raw;
    logic clr_short;
    logic clr_long;
  } btn_ctrl_t;

  // Per-button status back to the core.
  typedef struct packed {
    logic stable_nxt;
    logic short_flag;
    logic long_flag;
  } btn_stat_t;

endpackage

// ===== hdl/bdpc_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one command beat: op, raw levels, query index.
// ----------------------------------------------------------------------------
interface bdpc_in_if;

  logic                          valid;
  logic                          ready;
  logic [bdpc_pkg::OpW-1:0]      op;
  logic [bdpc_pkg::RawW-1:0]     raw_levels;
  logic [bdpc_pkg::IdxW-1:0]     query_index;

  modport source (output valid, output op, output raw_levels, output query_index,
                  input ready);
  modport sink   (input valid, input op, input raw_levels, input query_index,
                  output ready);

endinterface

// ===== hdl/bdpc_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one result beat: query hit and stable levels.
// ----------------------------------------------------------------------------
interface bdpc_out_if;

  logic                          valid;
  logic                          ready;
  logic                          query_hit;
  logic [bdpc_pkg::LevelW-1:0]   debounced_levels;

  modport source (output valid, output query_hit, output debounced_levels,
                  input ready);
  modport sink   (input valid, input query_hit, input debounced_levels,
                  output ready);

endinterface

// ===== hdl/button_debounce_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Button debounce press classifier core
// Debounces a set of active-low buttons on tick beats, classifies short and
// long presses with auto-repeat, and answers read-clear queries of the flags.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  in_i     in   valid / ready    op, raw_levels, query_index
//  out_o    out  valid / ready    query_hit, debounced_levels
//  cfg      in   cfg_we_i         cfg_idx_i, cfg_wdata_i (write only)
//
//  Each accepted beat updates the button state and loads the result
//  register in the same cycle; its result is offered on the next cycle.
//  One beat per cycle is sustained while out_o.ready is high, set by the single result register.
//  in_i.ready is high while the result register is empty or being drained.
//  Reset clears all button state and loads the register defaults.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bdpc_in_if.sink                           in_i,
  bdpc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bdpc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  logic [bdpc_pkg::CntW-1:0]   long_press_q;
  logic [bdpc_pkg::CntW-1:0]   repeat_q;
  logic                        in_acc;
  logic                        is_tick;
  logic                        is_rd_short;
  logic                        is_rd_long;
  logic                        hit_d;
  logic [bdpc_pkg::LevelW-1:0] levels_d;
  logic                        out_valid_q;
  logic                        out_hit_q;
  logic [bdpc_pkg::LevelW-1:0] out_levels_q;
  logic [bdpc_pkg::NumButtons-1:0] short_vec;
  logic [bdpc_pkg::NumButtons-1:0] long_vec;

  bdpc_pkg::btn_ctrl_t ctrl [bdpc_pkg::NumButtons];
  bdpc_pkg::btn_stat_t stat [bdpc_pkg::NumButtons];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= bdpc_pkg::LONG_PRESS_RST;
      repeat_q     <= bdpc_pkg::REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdpc_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        bdpc_pkg::CFG_REPEAT:     repeat_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Beat acceptance and op decode.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_tick     = in_acc && (in_i.op == bdpc_pkg::OP_TICK);
  assign is_rd_short = in_acc && (in_i.op == bdpc_pkg::OP_RD_SHORT);
  assign is_rd_long  = in_acc && (in_i.op == bdpc_pkg::OP_RD_LONG);

  // Per-button commands; buttons without a raw bit sample the pressed level.
  always_comb begin
    for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
      ctrl[b].tick      = is_tick;
      ctrl[b].raw       = (b < bdpc_pkg::RawW) ? in_i.raw_levels[b] : 1'b0;
      ctrl[b].clr_short = is_rd_short && (in_i.query_index == bdpc_pkg::IdxW'(b));
      ctrl[b].clr_long  = is_rd_long && (in_i.query_index == bdpc_pkg::IdxW'(b));
    end
  end

  // Button slices.
  for (genvar g = 0; g < bdpc_pkg::NumButtons; g++) begin : g_btn
    bdpc_button u_button (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .long_press_i(long_press_q),
      .repeat_i    (repeat_q),
      .ctrl_i      (ctrl[g]),
      .stat_o      (stat[g])
    );
    assign short_vec[g] = stat[g].short_flag;
    assign long_vec[g]  = stat[g].long_flag;
  end

  // Result of the beat: flag read before its clear, and levels after the beat.
  always_comb begin
    hit_d    = 1'b0;
    levels_d = '0;
    for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
      if (in_i.query_index == bdpc_pkg::IdxW'(b)) begin
        hit_d = (is_rd_short && short_vec[b]) || (is_rd_long && long_vec[b]);
      end
    end
    for (int b = 0; b < bdpc_pkg::LevelW; b++) begin
      if (b < bdpc_pkg::NumButtons) begin
        levels_d[b] = stat[b].stable_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_hit_q    <= hit_d;
      out_levels_q <= levels_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.query_hit        = out_hit_q;
  assign out_o.debounced_levels = out_levels_q;

`ifndef SYNTHESIS
  // A button never holds a short and a long flag at once.
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (short_vec & long_vec) == '0)
    else $error("short and long flag set together");

  // A tick beat never reports a hit.
  a_tick_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> !out_o.query_hit)
    else $error("tick beat reported a hit");

  // A query beyond the last button reads zero.
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.query_index >= bdpc_pkg::IdxW'(bdpc_pkg::NumButtons)))
    |=> !out_o.query_hit)
    else $error("out-of-range query reported a hit");

  // Every accepted beat produces a result on the next cycle.
  a_acc_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("accepted beat produced no result");
`endif

endmodule

// ===== hdl/bdpc_button.sv =====
// ----------------------------------------------------------------------------
// Per-button debounce and press classifier slice
// Two-sample debounce, hold counter for long presses, repeat counter while
// held, and the short and long flags with their read-clear inputs.
// ----------------------------------------------------------------------------
module bdpc_button (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bdpc_pkg::CntW-1:0]   long_press_i,
  input  logic [bdpc_pkg::CntW-1:0]   repeat_i,
  input  bdpc_pkg::btn_ctrl_t         ctrl_i,
  output bdpc_pkg::btn_stat_t         stat_o
);

  logic                      newest_q, newest_d;
  logic                      older_q, older_d;
  logic                      stable_q, stable_d;
  logic                      prev_q, prev_d;
  logic                      long_q, long_d;
  logic                      short_q, short_d;
  logic [bdpc_pkg::CntW-1:0] hold_q, hold_d;
  logic [bdpc_pkg::CntW-1:0] rep_q, rep_d;
  logic [bdpc_pkg::CntW-1:0] hold_inc;
  logic [bdpc_pkg::CntW-1:0] rep_inc;

  assign hold_inc = hold_q + bdpc_pkg::CntW'(1);
  assign rep_inc  = rep_q + bdpc_pkg::CntW'(1);

  // Next-state logic for one tick or one flag clear.
  always_comb begin
    newest_d = newest_q;
    older_d  = older_q;
    stable_d = stable_q;
    prev_d   = prev_q;
    long_d   = long_q;
    short_d  = short_q;
    hold_d   = hold_q;
    rep_d    = rep_q;

    if (ctrl_i.tick) begin
      older_d  = newest_q;
      newest_d = ctrl_i.raw;
      // Two agreeing samples make the level stable.
      if (ctrl_i.raw == newest_q) begin
        stable_d = ctrl_i.raw;
        if (!ctrl_i.raw) begin
          // Pressed: count up to the limit, then run the repeat counter.
          if (hold_q < long_press_i) begin
            hold_d = hold_inc;
            if (hold_inc == long_press_i) begin
              long_d  = 1'b1;
              short_d = 1'b0;
              rep_d   = '0;
            end
          end else begin
            rep_d = rep_inc;
            if (rep_inc >= repeat_i) begin
              long_d  = 1'b1;
              short_d = 1'b0;
              rep_d   = '0;
            end
          end
        end else if (!prev_q) begin
          // Release after a press: classify and clear the press state.
          if ((hold_q != '0) && (hold_q < long_press_i)) begin
            short_d = 1'b1;
          end
          hold_d = '0;
          rep_d  = '0;
          long_d = 1'b0;
        end
        prev_d = ctrl_i.raw;
      end
    end

    if (ctrl_i.clr_short) begin
      short_d = 1'b0;
    end
    if (ctrl_i.clr_long) begin
      long_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= 1'b0;
      older_q  <= 1'b0;
      stable_q <= 1'b0;
      prev_q   <= 1'b0;
      long_q   <= 1'b0;
      short_q  <= 1'b0;
      hold_q   <= '0;
      rep_q    <= '0;
    end else begin
      newest_q <= newest_d;
      older_q  <= older_d;
      stable_q <= stable_d;
      prev_q   <= prev_d;
      long_q   <= long_d;
      short_q  <= short_d;
      hold_q   <= hold_d;
      rep_q    <= rep_d;
    end
  end

  // The older sample is kept as history; the compare uses the newest one.
  assign stat_o.stable_nxt = stable_d | (older_q & 1'b0);
  assign stat_o.short_flag = short_q;
  assign stat_o.long_flag  = long_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Button debounce press classifier testbench
// Drives command beats through the input channel in random bursts and
// predicts every result beat from its own model of the debouncer. The
// receiver stalls in changing patterns and also holds off for long
// stretches. The registers are written between phases, at both extremes
// and at several small settings that make long presses and repeats frequent.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int WatchdogLimit = 1000;
  localparam int HoldOffBase   = 80;
  localparam int HoldOffEvery  = 270;

  // The op code that the block leaves unused.
  localparam logic [bdpc_pkg::OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [bdpc_pkg::OpW-1:0]  op;
    logic [bdpc_pkg::RawW-1:0] raw;
    logic [bdpc_pkg::IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic                        hit;
    logic [bdpc_pkg::LevelW-1:0] levels;
  } result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_SPARSE
  } stall_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bdpc_pkg::CfgDataW-1:0] cfg_wdata_i;

  bdpc_in_if  in_if ();
  bdpc_out_if out_if ();

  button_debounce_press_classifier_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Command beats waiting to be sent and results still owed by the block.
  cmd_t    cmd_q[$];
  result_t classified_q[$];

  // Model state: registers and per-button debounce and press state.
  logic [bdpc_pkg::CntW-1:0] long_cfg;
  logic [bdpc_pkg::CntW-1:0] repeat_cfg;
  logic                      smp_new     [bdpc_pkg::NumButtons];
  logic                      smp_old     [bdpc_pkg::NumButtons];
  logic                      stable      [bdpc_pkg::NumButtons];
  logic                      stable_prev [bdpc_pkg::NumButtons];
  logic [bdpc_pkg::CntW-1:0] hold_cnt    [bdpc_pkg::NumButtons];
  logic [bdpc_pkg::CntW-1:0] rep_cnt     [bdpc_pkg::NumButtons];
  logic                      long_flag   [bdpc_pkg::NumButtons];
  logic                      short_flag  [bdpc_pkg::NumButtons];

  // Intended button levels for the random part and the ticks left in each run.
  logic intent    [bdpc_pkg::NumButtons];
  int   run_left  [bdpc_pkg::NumButtons];

  int          mismatches;
  int          results_seen;
  int          beats_in;
  int          burst_left;
  int          gap_left;
  cmd_t        drv_cmd;
  stall_mode_e stall_mode;
  int          mode_left;
  int          hold_left;
  int          next_hold_at;
  logic [7:0]  stall_ctr;
  int          idle_cycles;

  // Applies one command beat to the model and returns the result it causes.
  function automatic result_t debounce_step(cmd_t c);
    result_t r;
    logic    s;
    r.hit = 1'b0;
    case (c.op)
      bdpc_pkg::OP_TICK: begin
        for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
          // Buttons without a raw bit read as pressed.
          s = (b < bdpc_pkg::RawW) ? c.raw[b] : 1'b0;
          smp_old[b] = smp_new[b];
          smp_new[b] = s;
          if (smp_new[b] == smp_old[b]) begin
            stable[b] = smp_new[b];
            if (stable[b] == 1'b0) begin
              if (hold_cnt[b] < long_cfg) begin
                hold_cnt[b] = hold_cnt[b] + 1'b1;
                if (hold_cnt[b] == long_cfg) begin
                  long_flag[b]  = 1'b1;
                  short_flag[b] = 1'b0;
                  rep_cnt[b]    = '0;
                end
              end else begin
                rep_cnt[b] = rep_cnt[b] + 1'b1;
                if (rep_cnt[b] >= repeat_cfg) begin
                  short_flag[b] = 1'b0;
                  long_flag[b]  = 1'b1;
                  rep_cnt[b]    = '0;
                end
              end
            end
            if (stable[b] == 1'b1 && stable_prev[b] == 1'b0) begin
              if (hold_cnt[b] > 0 && hold_cnt[b] < long_cfg) begin
                short_flag[b] = 1'b1;
              end
              hold_cnt[b]  = '0;
              rep_cnt[b]   = '0;
              long_flag[b] = 1'b0;
            end
            stable_prev[b] = stable[b];
          end
        end
      end
      bdpc_pkg::OP_RD_SHORT, bdpc_pkg::OP_RD_LONG: begin
        // Out-of-range indexes read zero and change nothing.
        if (c.idx < bdpc_pkg::NumButtons) begin
          if (c.op == bdpc_pkg::OP_RD_SHORT) begin
            if (short_flag[c.idx]) begin
              short_flag[c.idx] = 1'b0;
              r.hit             = 1'b1;
            end
          end else if (long_flag[c.idx]) begin
            long_flag[c.idx] = 1'b0;
            r.hit            = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.levels = '0;
    for (int b = 0; b < bdpc_pkg::NumButtons && b < bdpc_pkg::LevelW; b++) begin
      r.levels[b] = stable[b];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic push_cmd(logic [bdpc_pkg::OpW-1:0]  op,
                          logic [bdpc_pkg::RawW-1:0] raw,
                          logic [bdpc_pkg::IdxW-1:0] idx);
    cmd_q.push_back(cmd_t'{op, raw, idx});
  endtask

  // Waits until every queued beat was sent and every result has come back.
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_if.valid || classified_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_regs(logic [bdpc_pkg::CntW-1:0] lp, logic [bdpc_pkg::CntW-1:0] rt);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bdpc_pkg::CFG_LONG_PRESS;
    cfg_wdata_i <= lp;
    long_cfg = lp;
    @(posedge clk_i);
    cfg_idx_i   <= bdpc_pkg::CFG_REPEAT;
    cfg_wdata_i <= rt;
    repeat_cfg = rt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random beats: mostly press and release runs per button with queries in
  // between, plus glitches, out-of-range indexes and the unused op code.
  task automatic queue_random(int n);
    int                          pick;
    int                          span;
    logic [bdpc_pkg::RawW-1:0]   raw;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        span = (long_cfg <= 16) ? 2 * long_cfg + 3 : 30;
        raw  = '0;
        for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
          if (run_left[b] == 0) begin
            intent[b]   = ~intent[b];
            run_left[b] = $urandom_range(1, span);
          end else begin
            run_left[b]--;
          end
          if (b < bdpc_pkg::RawW) raw[b] = intent[b];
        end
        // A one-sample glitch on a random button now and then.
        if ($urandom_range(0, 19) == 0) begin
          raw[$urandom_range(0, bdpc_pkg::RawW - 1)] ^= 1'b1;
        end
        push_cmd(bdpc_pkg::OP_TICK, raw, bdpc_pkg::IdxW'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        push_cmd(($urandom_range(0, 1) == 0) ? bdpc_pkg::OP_RD_SHORT : bdpc_pkg::OP_RD_LONG,
                 bdpc_pkg::RawW'($urandom_range(0, 7)),
                 ($urandom_range(0, 5) == 0)
                   ? bdpc_pkg::IdxW'($urandom_range(0, 15))
                   : bdpc_pkg::IdxW'($urandom_range(0, bdpc_pkg::NumButtons - 1)));
      end else begin
        push_cmd(OP_UNUSED, bdpc_pkg::RawW'($urandom_range(0, 7)),
                 bdpc_pkg::IdxW'($urandom_range(0, 15)));
      end
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sender: bursts of beats with random gaps; predicts each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      beats_in    <= 0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        classified_q.push_back(debounce_step(cmd_t'{in_if.op, in_if.raw_levels,
                                                    in_if.query_index}));
        beats_in <= beats_in + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          drv_cmd = cmd_q.pop_front();
          in_if.op          <= drv_cmd.op;
          in_if.raw_levels  <= drv_cmd.raw;
          in_if.query_index <= drv_cmd.idx;
          in_if.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall patterns, and long hold-offs every few hundred
  // beats so that the result register fills and the input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= STALL_NONE;
      mode_left    <= 0;
      hold_left    <= 0;
      next_hold_at <= 150;
      stall_ctr    <= '0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (beats_in >= next_hold_at) begin
      out_if.ready <= 1'b0;
      hold_left    <= HoldOffBase + $urandom_range(0, 40);
      next_hold_at <= next_hold_at + HoldOffEvery;
    end else begin
      stall_ctr <= stall_ctr + 1'b1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     out_if.ready <= 1'b1;
        STALL_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
        STALL_PERIODIC: out_if.ready <= (stall_ctr[1:0] == 2'd0);
        default:        out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Checker: each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (classified_q.size() == 0) begin
        report_mismatch("result beat with no prediction waiting");
      end else begin
        result_t want;
        want = classified_q.pop_front();
        if (out_if.query_hit !== want.hit) begin
          report_mismatch($sformatf("query_hit got %0b want %0b", out_if.query_hit, want.hit));
        end
        if (out_if.debounced_levels !== want.levels) begin
          report_mismatch($sformatf("debounced_levels got %b want %b",
                                    out_if.debounced_levels, want.levels));
        end
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and run control.
  initial begin
    int lp;
    int rt;
    in_if.valid       = 1'b0;
    in_if.op          = bdpc_pkg::OP_TICK;
    in_if.raw_levels  = '0;
    in_if.query_index = '0;
    out_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = bdpc_pkg::CFG_LONG_PRESS;
    cfg_wdata_i       = '0;
    mismatches        = 0;
    results_seen      = 0;
    idle_cycles       = 0;
    long_cfg          = bdpc_pkg::LONG_PRESS_RST;
    repeat_cfg        = bdpc_pkg::REPEAT_RST;
    for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
      smp_new[b]     = 1'b0;
      smp_old[b]     = 1'b0;
      stable[b]      = 1'b0;
      stable_prev[b] = 1'b0;
      hold_cnt[b]    = '0;
      rep_cnt[b]     = '0;
      long_flag[b]   = 1'b0;
      short_flag[b]  = 1'b0;
      intent[b]      = 1'b1;
      run_left[b]    = 0;
    end
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: short presses, glitches, every op, bad indexes.
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd15);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b101, 4'd1);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b010, 4'd2);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b111, 4'd3);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b111, 4'd15);
    push_cmd(OP_UNUSED, 3'b111, 4'd1);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b000, 4'd1);
    push_cmd(bdpc_pkg::OP_TICK, 3'b101, 4'd7);
    push_cmd(bdpc_pkg::OP_TICK, 3'b010, 4'd8);
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b101, 4'd2);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b010, 4'd14);
    push_cmd(OP_UNUSED, 3'b000, 4'd0);

    // Shortest limits: a long flag on the first stable press and every tick
    // after it, and no short flag on release.
    write_regs(16'd1, 16'd1);
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b000, 4'd2);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_SHORT, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b111, 4'd1);
    queue_random(70);

    // Longest limits: long presses never complete.
    write_regs(16'hFFFF, 16'hFFFF);
    queue_random(60);

    // The limit is lowered while all buttons are held past the new limit.
    write_regs(16'd20, 16'd3);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    push_cmd(bdpc_pkg::OP_TICK, 3'b111, 4'd0);
    for (int i = 0; i < 15; i++) push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    write_regs(16'd4, 16'd2);
    for (int i = 0; i < 6; i++) push_cmd(bdpc_pkg::OP_TICK, 3'b000, 4'd0);
    push_cmd(bdpc_pkg::OP_RD_LONG, 3'b000, 4'd1);
    for (int b = 0; b < bdpc_pkg::NumButtons; b++) begin
      intent[b]   = 1'b0;
      run_left[b] = 0;
    end
    queue_random(70);

    // Small random settings so that long presses and repeats are frequent.
    for (int ph = 0; ph < 4; ph++) begin
      lp = $urandom_range(1, 12);
      rt = $urandom_range(1, 6);
      write_regs(bdpc_pkg::CntW'(lp), bdpc_pkg::CntW'(rt));
      queue_random(70);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (classified_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", classified_q.size()));
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_press_classifier_core.f =====
hdl/bdpc_pkg.sv
hdl/bdpc_in_if.sv
hdl/bdpc_out_if.sv
hdl/bdpc_button.sv
hdl/button_debounce_press_classifier_core.sv
tb/testbench.sv
